FILE: src/bsm_pkg.sv
// Shared types and constants for the bank switch mapper with scanline IRQ.
// No dependencies; used by bsm_banks, bsm_irq and the top level.
package bsm_pkg;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  localparam logic [CfgIdxW-1:0] CfgPrgAndMask = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPrgOrBits  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgChrAndMask = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgChrOrBits  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgHeaderMode = 3'd4;

  localparam logic [7:0] PrgAndMaskRst = 8'd63;
  localparam logic [9:0] ChrAndMaskRst = 10'd255;

  // A12 low-time filter
  localparam int unsigned TimerW       = 4;
  localparam int unsigned A12FilterDef = 8;

  // Word kinds
  localparam logic KindCpu = 1'b0;
  localparam logic KindPpu = 1'b1;

  // CPU register pairs
  localparam logic [1:0] PairBank   = 2'd0;
  localparam logic [1:0] PairMirror = 2'd1;
  localparam logic [1:0] PairIrqLat = 2'd2;
  localparam logic [1:0] PairIrqEn  = 2'd3;

  // Bank commands (low three bits of the command byte)
  localparam logic [2:0] CmdChr2k0 = 3'd0;
  localparam logic [2:0] CmdChr2k1 = 3'd1;
  localparam logic [2:0] CmdChr1k0 = 3'd2;
  localparam logic [2:0] CmdChr1k1 = 3'd3;
  localparam logic [2:0] CmdChr1k2 = 3'd4;
  localparam logic [2:0] CmdChr1k3 = 3'd5;
  localparam logic [2:0] CmdPrg0   = 3'd6;
  localparam logic [2:0] CmdPrg1   = 3'd7;

  // Fixed PRG banks and reset selections
  localparam logic [5:0] PrgFixed2nd  = 6'h3E;
  localparam logic [5:0] PrgFixedLast = 6'h3F;
  localparam logic [5:0] PrgSel0Rst   = 6'h3C;
  localparam logic [5:0] PrgSel1Rst   = 6'h3D;

  typedef struct packed {
    logic       kind;
    logic [1:0] reg_pair;
    logic       addr_odd;
    logic [7:0] write_value;
    logic       ppu_a12;
    logic [1:0] prg_slot;
    logic [2:0] chr_slot;
  } bsm_in_t;

  typedef struct packed {
    logic       irq_line;
    logic [7:0] prg_bank;
    logic [9:0] chr_bank;
    logic       mirror_horizontal;
    logic       wram_enabled;
    logic       wram_writable;
  } bsm_out_t;

  // CPU register write, qualified by the stage advancing
  typedef struct packed {
    logic       we;
    logic [1:0] pair;
    logic       odd;
    logic [7:0] value;
  } bsm_wr_t;

endpackage

FILE: src/bank_switch_mapper_with_scanline_irq.sv
// Bank switch mapper with scanline IRQ: top level, handshake and pipeline.
// Depends on bsm_pkg, bsm_banks and bsm_irq.
//
// Each input word is either one CPU register write or one PPU cycle; every
// word yields exactly one result word carrying the IRQ line, the translated
// PRG bank for prg_slot, the translated CHR bank for chr_slot, mirroring and
// the work-RAM flags, all as seen after that word has updated the state.
// The block takes one word per cycle: a word waits in the input register,
// the state update and bank translation run in a single pass of short
// logic, and the result lands in the output register, so a word accepted
// into the input register moves on to the result register as soon as the
// result register is free. The result register holds a
// finished word while the next one waits in the input register; throughput
// drops only when out_ready_i is low.
// Configuration registers (AND/OR masks, header mode) are written through a
// plain write port and should only change while no words are in flight.
module bank_switch_mapper_with_scanline_irq #(
  parameter int unsigned A12_FILTER = bsm_pkg::A12FilterDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bsm_pkg::bsm_in_t              in_data_i,
  // result words
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bsm_pkg::bsm_out_t             out_data_o,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [bsm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bsm_pkg::CfgDataW-1:0]  cfg_data_i
);

  // configuration registers
  logic [7:0] prg_and_q;
  logic [7:0] prg_or_q;
  logic [9:0] chr_and_q;
  logic [9:0] chr_or_q;
  logic       header_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_and_q <= bsm_pkg::PrgAndMaskRst;
      prg_or_q  <= '0;
      chr_and_q <= bsm_pkg::ChrAndMaskRst;
      chr_or_q  <= '0;
      header_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bsm_pkg::CfgPrgAndMask: prg_and_q <= cfg_data_i[7:0];
        bsm_pkg::CfgPrgOrBits:  prg_or_q  <= cfg_data_i[7:0];
        bsm_pkg::CfgChrAndMask: chr_and_q <= cfg_data_i;
        bsm_pkg::CfgChrOrBits:  chr_or_q  <= cfg_data_i;
        bsm_pkg::CfgHeaderMode: header_q  <= cfg_data_i[0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // input register
  bsm_pkg::bsm_in_t  in_q;
  logic              in_vld_q;
  // result register
  bsm_pkg::bsm_out_t out_q, out_d;
  logic              out_vld_q;

  logic              advance;  // input word moves into the result register
  bsm_pkg::bsm_wr_t  wr;
  logic              ppu_cyc;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= (in_valid_i && in_ready_o) || (in_vld_q && !advance);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // state only moves when the word leaves the input register
  assign wr.we    = advance && in_q.kind == bsm_pkg::KindCpu;
  assign wr.pair  = in_q.reg_pair;
  assign wr.odd   = in_q.addr_odd;
  assign wr.value = in_q.write_value;
  assign ppu_cyc  = advance && in_q.kind == bsm_pkg::KindPpu;

  bsm_banks u_banks (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_i           (wr),
    .prg_and_mask_i (prg_and_q),
    .prg_or_bits_i  (prg_or_q),
    .chr_and_mask_i (chr_and_q),
    .chr_or_bits_i  (chr_or_q),
    .header_mode_i  (header_q),
    .prg_slot_i     (in_q.prg_slot),
    .chr_slot_i     (in_q.chr_slot),
    .prg_bank_o     (out_d.prg_bank),
    .chr_bank_o     (out_d.chr_bank),
    .mirror_o       (out_d.mirror_horizontal),
    .wram_en_o      (out_d.wram_enabled),
    .wram_wr_o      (out_d.wram_writable)
  );

  bsm_irq #(
    .A12_FILTER (A12_FILTER)
  ) u_irq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .ppu_i  (ppu_cyc),
    .a12_i  (in_q.ppu_a12),
    .irq_o  (out_d.irq_line)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= advance || (out_vld_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // a word leaving the input register always shows up as a result
  a_advance_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("advanced word did not reach the result register");

  // an empty input register never refuses a word
  a_empty_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> in_ready_o)
    else $error("input register empty but not ready");

  // IRQ disable write clears the pending line in its own result
  a_irq_disable_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.we && wr.pair == bsm_pkg::PairIrqEn && !wr.odd |=> !out_data_o.irq_line)
    else $error("IRQ disable left the line pending");

  // header mode forces work RAM on and writable on a control write
  a_header_wram : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.we && wr.pair == bsm_pkg::PairMirror && wr.odd && header_q
    |=> out_data_o.wram_enabled && out_data_o.wram_writable)
    else $error("header mode did not force work RAM on");

endmodule

FILE: src/bsm_banks.sv
// Bank registers, mirroring and work-RAM control, plus PRG/CHR translation.
// Depends on bsm_pkg.
module bsm_banks (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bsm_pkg::bsm_wr_t wr_i,
  input  logic [7:0]       prg_and_mask_i,
  input  logic [7:0]       prg_or_bits_i,
  input  logic [9:0]       chr_and_mask_i,
  input  logic [9:0]       chr_or_bits_i,
  input  logic             header_mode_i,
  input  logic [1:0]       prg_slot_i,
  input  logic [2:0]       chr_slot_i,
  output logic [7:0]       prg_bank_o,
  output logic [9:0]       chr_bank_o,
  output logic             mirror_o,
  output logic             wram_en_o,
  output logic             wram_wr_o
);

  // Only the command bits that matter are kept
  logic       chr_inv_q, chr_inv_d;
  logic       prg_swap_q, prg_swap_d;
  logic [2:0] cmd_sel_q, cmd_sel_d;
  logic [5:0] prg_q [2];
  logic [5:0] prg_d [2];
  logic [7:0] chr_q [8];
  logic [7:0] chr_d [8];
  logic       mirror_q, mirror_d;
  logic       wram_en_q, wram_en_d;
  logic       wram_wp_q, wram_wp_d;

  logic [1:0] prg_sel_slot;
  logic [5:0] prg_raw;
  logic [2:0] chr_idx;

  always_comb begin
    chr_inv_d  = chr_inv_q;
    prg_swap_d = prg_swap_q;
    cmd_sel_d  = cmd_sel_q;
    prg_d      = prg_q;
    chr_d      = chr_q;
    mirror_d   = mirror_q;
    wram_en_d  = wram_en_q;
    wram_wp_d  = wram_wp_q;
    if (wr_i.we && wr_i.pair == bsm_pkg::PairBank) begin
      if (!wr_i.odd) begin
        chr_inv_d  = wr_i.value[7];
        prg_swap_d = wr_i.value[6];
        cmd_sel_d  = wr_i.value[2:0];
      end else begin
        unique case (cmd_sel_q)
          bsm_pkg::CmdChr2k0: begin
            chr_d[0] = {wr_i.value[7:1], 1'b0};
            chr_d[1] = {wr_i.value[7:1], 1'b1};
          end
          bsm_pkg::CmdChr2k1: begin
            chr_d[2] = {wr_i.value[7:1], 1'b0};
            chr_d[3] = {wr_i.value[7:1], 1'b1};
          end
          bsm_pkg::CmdChr1k0: chr_d[4] = wr_i.value;
          bsm_pkg::CmdChr1k1: chr_d[5] = wr_i.value;
          bsm_pkg::CmdChr1k2: chr_d[6] = wr_i.value;
          bsm_pkg::CmdChr1k3: chr_d[7] = wr_i.value;
          bsm_pkg::CmdPrg0:   prg_d[0] = wr_i.value[5:0];
          bsm_pkg::CmdPrg1:   prg_d[1] = wr_i.value[5:0];
          default:            prg_d[1] = wr_i.value[5:0];
        endcase
      end
    end
    if (wr_i.we && wr_i.pair == bsm_pkg::PairMirror) begin
      if (wr_i.odd) begin
        // header mode pins work RAM to enabled and writable
        wram_en_d = header_mode_i ? 1'b1 : wr_i.value[7];
        wram_wp_d = header_mode_i ? 1'b0 : wr_i.value[6];
      end else begin
        mirror_d = wr_i.value[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chr_inv_q  <= 1'b0;
      prg_swap_q <= 1'b0;
      cmd_sel_q  <= '0;
      prg_q[0]   <= bsm_pkg::PrgSel0Rst;
      prg_q[1]   <= bsm_pkg::PrgSel1Rst;
      for (int i = 0; i < 8; i++) begin
        chr_q[i] <= 8'(i);
      end
      mirror_q   <= 1'b0;
      wram_en_q  <= 1'b0;
      wram_wp_q  <= 1'b0;
    end else begin
      chr_inv_q  <= chr_inv_d;
      prg_swap_q <= prg_swap_d;
      cmd_sel_q  <= cmd_sel_d;
      prg_q      <= prg_d;
      chr_q      <= chr_d;
      mirror_q   <= mirror_d;
      wram_en_q  <= wram_en_d;
      wram_wp_q  <= wram_wp_d;
    end
  end

  // Translation works on the updated state
  always_comb begin
    prg_sel_slot = prg_slot_i;
    if (!prg_slot_i[0]) begin
      prg_sel_slot[1] = prg_slot_i[1] ^ prg_swap_d;
    end
    unique case (prg_sel_slot)
      2'd0:    prg_raw = prg_d[0];
      2'd1:    prg_raw = prg_d[1];
      2'd2:    prg_raw = bsm_pkg::PrgFixed2nd;
      default: prg_raw = bsm_pkg::PrgFixedLast;
    endcase
  end

  assign chr_idx    = chr_slot_i ^ {chr_inv_d, 2'b00};
  assign prg_bank_o = ({2'b00, prg_raw} & prg_and_mask_i) | prg_or_bits_i;
  assign chr_bank_o = ({2'b00, chr_d[chr_idx]} & chr_and_mask_i) | chr_or_bits_i;
  assign mirror_o   = mirror_d;
  assign wram_en_o  = wram_en_d;
  assign wram_wr_o  = ~wram_wp_d;

endmodule

FILE: src/bsm_irq.sv
// Scanline IRQ counter with A12 low-time filter.
// Depends on bsm_pkg.
module bsm_irq #(
  parameter int unsigned A12_FILTER = bsm_pkg::A12FilterDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bsm_pkg::bsm_wr_t wr_i,
  input  logic             ppu_i,     // PPU cycle word, stage advancing
  input  logic             a12_i,
  output logic             irq_o      // pending after this word
);

  logic [bsm_pkg::TimerW-1:0] timer_q, timer_d, timer_dec;
  logic [7:0] count_q, count_d, count_next;
  logic [7:0] reload_val_q, reload_val_d;
  logic       reload_req_q, reload_req_d;
  logic       enable_q, enable_d;
  logic       pending_q, pending_d;
  logic       ctr_clk;

  assign timer_dec  = (timer_q != '0) ? timer_q - 1'b1 : '0;
  assign ctr_clk    = ppu_i && timer_dec == '0 && a12_i;
  assign count_next = (count_q == '0 || reload_req_q) ? reload_val_q : count_q - 8'd1;

  always_comb begin
    timer_d      = timer_q;
    count_d      = count_q;
    reload_val_d = reload_val_q;
    reload_req_d = reload_req_q;
    enable_d     = enable_q;
    pending_d    = pending_q;
    if (ppu_i) begin
      timer_d = a12_i ? bsm_pkg::TimerW'(A12_FILTER) : timer_dec;
    end
    if (ctr_clk) begin
      count_d      = count_next;
      reload_req_d = 1'b0;
      if ((count_q != '0 || reload_req_q) && count_next == '0 && enable_q) begin
        pending_d = 1'b1;
      end
    end
    if (wr_i.we && wr_i.pair == bsm_pkg::PairIrqLat) begin
      if (wr_i.odd) begin
        count_d      = '0;
        reload_req_d = 1'b1;
      end else begin
        reload_val_d = wr_i.value;
      end
    end
    if (wr_i.we && wr_i.pair == bsm_pkg::PairIrqEn) begin
      enable_d = wr_i.odd;
      if (!wr_i.odd) begin
        pending_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q      <= '0;
      count_q      <= '0;
      reload_val_q <= '0;
      reload_req_q <= 1'b0;
      enable_q     <= 1'b0;
      pending_q    <= 1'b0;
    end else begin
      timer_q      <= timer_d;
      count_q      <= count_d;
      reload_val_q <= reload_val_d;
      reload_req_q <= reload_req_d;
      enable_q     <= enable_d;
      pending_q    <= pending_d;
    end
  end

  assign irq_o = pending_d;

endmodule
